/* rtl/rpn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg
// shared types and codes for the postfix expression evaluator
// ----------------------------------------------------------------------------
package rpn_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_SUB  = 2'd2,
        CMD_MUL  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_SAT   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_ROUND,
        S_WRBACK
    } t_state;

    localparam int unsigned VALUE_W = 32;

    typedef struct packed {
        logic start;
        t_cmd cmd;
    } t_alu_req;

    typedef struct packed {
        logic                      sat;
        logic signed [VALUE_W-1:0] value;
    } t_alu_res;

endpackage

/* rtl/rpn_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

/* rtl/rpn_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_alu
// two-stage saturating add, subtract and fixed-point multiply
// ----------------------------------------------------------------------------
module rpn_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  rpn_pkg::t_alu_req                  i_req,
    input  logic signed [rpn_pkg::VALUE_W-1:0] i_a,
    input  logic signed [rpn_pkg::VALUE_W-1:0] i_b,
    output rpn_pkg::t_alu_res                  o_res
);
    import rpn_pkg::*;

    localparam int PW = 2 * VALUE_W;
    localparam logic signed [PW-1:0] RND =
        (FRAC_BITS > 0) ? (PW'(1) <<< ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0)) : '0;
    localparam logic signed [PW-1:0] MAXV = PW'({1'b0, {(VALUE_W-1){1'b1}}});
    localparam logic signed [PW-1:0] MINV = -MAXV - PW'(1);

    logic signed [VALUE_W:0] r_sum;
    logic signed [PW-1:0]    r_prod;
    logic                    r_is_mul;

    logic signed [PW-1:0] n_wide;
    logic signed [PW-1:0] n_shift;
    t_alu_res             n_res;

    // stage one: raw sum, difference or full product
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_is_mul <= (i_req.cmd == CMD_MUL);
            if (i_req.cmd == CMD_SUB) begin
                r_sum <= (VALUE_W+1)'(i_a) - (VALUE_W+1)'(i_b);
            end else begin
                r_sum <= (VALUE_W+1)'(i_a) + (VALUE_W+1)'(i_b);
            end
            r_prod <= PW'(i_a) * PW'(i_b);
        end
    end

    // stage two: round to nearest (halves upward), then clamp
    always_comb begin
        n_shift = (r_prod + RND) >>> FRAC_BITS;
        n_wide  = r_is_mul ? n_shift : PW'(r_sum);
        if (n_wide > MAXV) begin
            n_res.sat   = 1'b1;
            n_res.value = MAXV[VALUE_W-1:0];
        end else if (n_wide < MINV) begin
            n_res.sat   = 1'b1;
            n_res.value = MINV[VALUE_W-1:0];
        end else begin
            n_res.sat   = 1'b0;
            n_res.value = n_wide[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_res <= n_res;
    end

endmodule

/* rtl/postfix_expression_evaluator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// reverse polish evaluator over a ram-held q16.16 operand stack
// ----------------------------------------------------------------------------
//  channel | dir | tdata                            | tuser        | tlast
//  s_*     | in  | operand_value[31:0]              | command[1:0] | finish
//  m_*     | out | value[31:0], stack_depth[36:32]  | status[1:0]  | -
//
//  each token passes through accept, stack read, alu stage one,
//  alu stage two and write-back, in that order
//  write-back waits while the previous result still sits in the output register
//  a new token is accepted while a result waits to be taken
//  synchronous active-low reset empties the stack; stack contents are not cleared
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_core #(
    parameter int DEPTH     = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // token input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // operand_value[31:0]
    input  logic [1:0]  s_tuser,   // command[1:0]
    input  logic        s_tlast,   // finish
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // value[31:0], stack_depth[36:32], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);
    import rpn_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = $clog2(DEPTH + 1);
    localparam logic [SW-1:0] FULL = SW'(DEPTH);
    localparam logic [SW-1:0] ONE  = SW'(1);
    localparam logic [SW-1:0] TWO  = SW'(2);

    // fsm and token registers
    t_state r_state, n_state;
    logic [SW-1:0]             r_sp, n_sp;
    t_cmd                      r_cmd;
    logic                      r_fin;
    logic signed [VALUE_W-1:0] r_opv;
    logic signed [VALUE_W-1:0] r_top;

    // output register
    logic                      r_m_valid, n_m_valid;
    logic signed [VALUE_W-1:0] r_m_value, n_m_value;
    t_status                   r_m_status, n_m_status;
    logic [SW-1:0]             r_m_depth, n_m_depth;

    // memory and alu wiring
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [VALUE_W-1:0]        mem_wdata;
    logic [AW-1:0]             raddr_top, raddr_next;
    logic [VALUE_W-1:0]        rdata_top, rdata_next;
    logic signed [VALUE_W-1:0] op_first, op_second;
    t_alu_req                  alu_req;
    t_alu_res                  alu_res;

    logic                      s_fire;
    logic                      out_free;
    logic [SW-1:0]             base_sp;
    logic [SW+4:0]             depth_ext;

    assign s_tready = (r_state == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !r_m_valid || m_tready;

    // read the top two entries; addresses only matter when those entries exist
    assign raddr_top  = (r_sp >= ONE) ? AW'(r_sp - ONE) : '0;
    assign raddr_next = (r_sp >= TWO) ? AW'(r_sp - TWO) : '0;

    // popping an empty slot gives zero; first is the deeper entry
    assign op_second = (r_sp >= ONE) ? $signed(rdata_top) : '0;
    assign op_first  = (r_sp >= TWO) ? $signed(rdata_next) : '0;

    assign alu_req = {(r_state == S_FETCH), r_cmd};

    // where an operator result lands once two entries are popped
    assign base_sp = (r_sp >= TWO) ? (r_sp - TWO) : '0;

    rpn_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (raddr_top),
        .o_rdata_a (rdata_top),
        .i_raddr_b (raddr_next),
        .o_rdata_b (rdata_next)
    );

    rpn_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .i_clk (i_clk),
        .i_req (alu_req),
        .i_a   (op_first),
        .i_b   (op_second),
        .o_res (alu_res)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sp      <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sp      <= n_sp;
            r_m_valid <= n_m_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_cmd <= t_cmd'(s_tuser);
            r_fin <= s_tlast;
            r_opv <= $signed(s_tdata);
        end
        if (r_state == S_FETCH) begin
            // kept for a finish after a push onto a full stack
            r_top <= $signed(rdata_top);
        end
        r_m_value  <= n_m_value;
        r_m_status <= n_m_status;
        r_m_depth  <= n_m_depth;
    end

    // next state, stack update and result
    always_comb begin
        n_state    = r_state;
        n_sp       = r_sp;
        n_m_valid  = r_m_valid;
        n_m_value  = r_m_value;
        n_m_status = r_m_status;
        n_m_depth  = r_m_depth;
        mem_we     = 1'b0;
        mem_waddr  = AW'(r_sp);
        mem_wdata  = r_opv;

        // result taken downstream
        if (r_m_valid && m_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_state = S_WRBACK;
            end
            S_WRBACK: begin
                if (out_free) begin
                    n_state   = S_IDLE;
                    n_m_valid = 1'b1;
                    if (r_cmd == CMD_PUSH) begin
                        if (r_sp >= FULL) begin
                            // full stack: value dropped
                            n_m_status = ST_OVER;
                            if (r_fin) begin
                                n_m_value = r_top;
                                n_sp      = r_sp - ONE;
                            end else begin
                                n_m_value = r_opv;
                            end
                        end else begin
                            mem_we     = 1'b1;
                            mem_waddr  = AW'(r_sp);
                            mem_wdata  = r_opv;
                            n_m_status = ST_OK;
                            n_m_value  = r_opv;
                            n_sp       = r_fin ? r_sp : (r_sp + ONE);
                        end
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(base_sp);
                        mem_wdata = alu_res.value;
                        n_m_value = alu_res.value;
                        if (r_sp < TWO) begin
                            n_m_status = ST_UNDER;
                        end else if (alu_res.sat) begin
                            n_m_status = ST_SAT;
                        end else begin
                            n_m_status = ST_OK;
                        end
                        // a finish pops straight back the entry just written
                        n_sp = r_fin ? base_sp : (base_sp + ONE);
                    end
                    n_m_depth = n_sp;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign depth_ext = {5'b0, r_m_depth};
    assign m_tvalid  = r_m_valid;
    assign m_tdata   = {3'b0, depth_ext[4:0], r_m_value};
    assign m_tuser   = r_m_status;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the postfix expression evaluator: tokens are driven
// from a queue with random gaps, results are taken with random stalls, and
// every result transaction is checked against a local stack calculator
// ----------------------------------------------------------------------------
module tb_top;

    import rpn_pkg::*;

    localparam int DEPTH         = 16;
    localparam int FRAC_BITS     = 16;
    localparam int RANDOM_TOKENS = 1300;
    // idle time after the last result before the run ends
    localparam int DRAIN_CYCLES  = 32;

    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

    // one token as presented on the slave side
    typedef struct {
        t_cmd        cmd;
        logic        fin;
        logic [31:0] operand;
    } t_token;

    // one result as expected on the master side
    typedef struct {
        logic signed [31:0] value;
        t_status            status;
        logic [4:0]         depth;
    } t_result;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // operand_value[31:0]
    logic [1:0]  s_tuser  = '0;    // command[1:0]
    logic        s_tlast  = 1'b0;  // finish
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // value[31:0], stack_depth[36:32], zero pad
    logic [1:0]  m_tuser;          // status[1:0]

    t_token  token_queue[$];
    t_result results_due[$];

    // local copy of the operand stack
    logic signed [31:0] calc_stack [DEPTH];
    int unsigned        calc_depth = 0;

    // depth as tracked while the token stream is built
    int unsigned gen_depth = 0;

    int     fail_count = 0;
    logic   tok_taken  = 1'b0;
    int     gap_left   = 0;
    int     calm_in    = 0;
    int     stall_left = 0;
    int     calm_out   = 0;
    t_token next_tok;
    t_result want;

    postfix_expression_evaluator_core #(
        .DEPTH     (DEPTH),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // stack calculator
    // ------------------------------------------------------------------------

    // an empty stack gives zero and flags underflow
    task automatic pop_operand(output logic signed [31:0] v, inout t_status st);
        if (calc_depth == 0) begin
            st = ST_UNDER;
            v  = '0;
        end else begin
            calc_depth--;
            v = calc_stack[calc_depth];
        end
    endtask

    task automatic saturate(input logic signed [63:0] wide, output logic signed [31:0] v,
                            inout t_status st);
        if (wide > Q_MAX) begin
            st = ST_SAT;
            v  = Q_MAX[31:0];
        end else if (wide < Q_MIN) begin
            st = ST_SAT;
            v  = Q_MIN[31:0];
        end else begin
            v = wide[31:0];
        end
    endtask

    task automatic evaluate_token(input t_cmd cmd, input logic fin,
                                  input logic signed [31:0] opv);
        t_status            st, ust, sst, fst;
        logic signed [31:0] lhs, rhs, val;
        logic signed [63:0] a64, b64, wide;
        t_result            r;
        st  = ST_OK;
        ust = ST_OK;
        sst = ST_OK;
        fst = ST_OK;
        if (cmd == CMD_PUSH) begin
            val = opv;
            // a full stack drops the operand
            if (calc_depth >= DEPTH) begin
                st = ST_OVER;
            end else begin
                calc_stack[calc_depth] = opv;
                calc_depth++;
            end
        end else begin
            // top of stack is the right-hand operand
            pop_operand(rhs, ust);
            pop_operand(lhs, ust);
            a64 = lhs;
            b64 = rhs;
            case (cmd)
                CMD_ADD: begin
                    wide = a64 + b64;
                end
                CMD_SUB: begin
                    wide = a64 - b64;
                end
                default: begin
                    // round to nearest, halves towards plus infinity
                    wide = a64 * b64;
                    if (FRAC_BITS > 0) wide = wide + (64'sd1 <<< (FRAC_BITS - 1));
                    wide = wide >>> FRAC_BITS;
                end
            endcase
            saturate(wide, val, sst);
            calc_stack[calc_depth] = val;
            calc_depth++;
            st = (ust != ST_OK) ? ust : sst;
        end
        if (fin) begin
            pop_operand(val, fst);
            if (st == ST_OK) st = fst;
        end
        r.value  = val;
        r.status = st;
        r.depth  = calc_depth[4:0];
        results_due.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic add_token(input t_cmd cmd, input logic fin, input logic [31:0] operand);
        t_token t;
        t.cmd     = cmd;
        t.fin     = fin;
        t.operand = operand;
        token_queue.push_back(t);
        if (cmd == CMD_PUSH) begin
            if (gen_depth < DEPTH) gen_depth++;
        end else begin
            gen_depth = (gen_depth < 2) ? 1 : gen_depth - 1;
        end
        if (fin && gen_depth > 0) gen_depth--;
    endtask

    // small q16.16 values often, corner values at times, otherwise anything
    function automatic logic [31:0] pick_operand();
        int r;
        r = $urandom_range(99);
        if (r < 40) return $urandom_range(32'h0007_FFFF) - 32'h0004_0000;
        if (r < 55) begin
            case ($urandom_range(7))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                4: return 32'h0000_8000;
                5: return 32'hFFFF_8000;
                6: return 32'h0001_0000;
                default: return 32'hFFFF_0000;
            endcase
        end
        return $urandom;
    endfunction

    // mostly short idle stretches, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // token driver, changes inputs at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || tok_taken) begin
            // nothing held, so either idle or present the next token
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (token_queue.size() > 0) begin
                next_tok = token_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_tok.operand;
                s_tuser  <= next_tok.cmd;
                s_tlast  <= next_tok.fin;
                if (calm_in > 0) begin
                    calm_in--;
                    gap_left = 0;
                end else if ($urandom_range(63) == 0) begin
                    calm_in  = $urandom_range(20, 80);
                    gap_left = 0;
                end else begin
                    gap_left = idle_len();
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result sink back-pressure
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (calm_out > 0) begin
                calm_out--;
            end else if ($urandom_range(63) == 0) begin
                calm_out = $urandom_range(20, 80);
            end else if ($urandom_range(99) < 30) begin
                stall_left = idle_len();
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on each token transaction, checks each result
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        tok_taken = i_rst_n && s_tvalid && s_tready;
        if (tok_taken) evaluate_token(t_cmd'(s_tuser), s_tlast, s_tdata);
        if (i_rst_n && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $error("result transaction with no expectation waiting");
                fail_count++;
            end else begin
                want = results_due.pop_front();
                if (m_tdata[31:0] !== want.value) begin
                    $error("value: expected %h, actual %h", want.value, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[36:32] !== want.depth) begin
                    $error("stack_depth: expected %0d, actual %0d", want.depth,
                           m_tdata[36:32]);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // token stream, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int   made;
        int   pushes_left;
        int   r;
        t_cmd c;
        logic f;

        // operators on an empty stack underflow, the zero result still lands
        add_token(CMD_ADD, 1'b0, 32'hFFFF_FFFF);
        add_token(CMD_MUL, 1'b1, 32'h0000_0000);
        // push then finish straight away
        add_token(CMD_PUSH, 1'b1, 32'h0001_8000);
        // saturation at both ends
        add_token(CMD_PUSH, 1'b0, 32'h7FFF_FFFF);
        add_token(CMD_PUSH, 1'b0, 32'h7FFF_FFFF);
        add_token(CMD_ADD,  1'b0, 32'h0000_0000);
        add_token(CMD_PUSH, 1'b0, 32'h8000_0000);
        add_token(CMD_SUB,  1'b0, 32'h0000_0000);
        add_token(CMD_PUSH, 1'b0, 32'h8000_0000);
        add_token(CMD_MUL,  1'b0, 32'h0000_0000);
        add_token(CMD_PUSH, 1'b0, 32'h8000_0000);
        // saturation status beats the finishing pop
        add_token(CMD_ADD,  1'b1, 32'h0000_0000);
        // multiply rounding on exact halves, both signs
        add_token(CMD_PUSH, 1'b0, 32'h0000_0001);
        add_token(CMD_PUSH, 1'b0, 32'h0000_8000);
        add_token(CMD_MUL,  1'b0, 32'h0000_0000);
        add_token(CMD_PUSH, 1'b0, 32'hFFFF_8000);
        add_token(CMD_MUL,  1'b0, 32'h0000_0000);
        add_token(CMD_SUB,  1'b1, 32'h0000_0000);
        // fill the stack, then push onto it while full
        while (gen_depth < DEPTH) add_token(CMD_PUSH, 1'b0, pick_operand());
        add_token(CMD_PUSH, 1'b0, 32'h1234_5678);
        add_token(CMD_PUSH, 1'b1, 32'hEDCB_A987);

        // random expressions with a little noise mixed in
        made        = 0;
        pushes_left = 0;
        while (made < RANDOM_TOKENS) begin
            if (pushes_left == 0 && gen_depth <= 1) begin
                r = $urandom_range(99);
                if (r < 70) pushes_left = $urandom_range(2, 5);
                else if (r < 92) pushes_left = $urandom_range(6, 12);
                else pushes_left = $urandom_range(13, 20);
            end
            if ($urandom_range(99) < 8) begin
                add_token(t_cmd'($urandom_range(3)), ($urandom_range(1) == 1), $urandom);
            end else if (pushes_left > 0 && (gen_depth < 2 || $urandom_range(99) < 65)) begin
                pushes_left--;
                add_token(CMD_PUSH, ($urandom_range(99) < 3), pick_operand());
            end else if (gen_depth >= 2) begin
                c = t_cmd'($urandom_range(1, 3));
                // usually close the expression once it folds down to one entry
                if (pushes_left == 0 && gen_depth == 2) f = ($urandom_range(99) < 80);
                else f = ($urandom_range(99) < 3);
                add_token(c, f, $urandom);
            end else begin
                add_token(CMD_PUSH, 1'b0, pick_operand());
            end
            made++;
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (token_queue.size() != 0 || s_tvalid) @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && results_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #(15_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule
